// ===== hw/rtl/bdq_pkg.sv =====
// Shared types for the bounded deque: operation codes and sequencer states.
`default_nettype none

package bdq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DEL_FIRST  = 3'd4,
		OP_DEL_ALL    = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RDIDX,
		ST_FETCH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_mem.sv =====
// Entry store: one write port, two registered read ports.
`default_nettype none

module bdq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_match_delete.sv =====
// Bounded double-ended queue with match deletion over a circular entry store.
//
// One word is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver has
// no way to hold it off. From accept, the sequencer passes through EXEC, then
// RDIDX for a read whose index is in range or SCAN for a match deletion, then
// FETCH and DONE. A match deletion streams every held entry through one read
// port and one write port of the store, one entry per cycle, closing gaps in
// place. After each result the sequencer returns to IDLE with busy low before
// it takes the next word. The store needs no clearing after reset.
`default_nettype none

module bounded_deque_with_match_delete
	import bdq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   mode,
	input  wire logic [WIDTH-1:0]             value,
	input  wire logic [$clog2(DEPTH)-1:0]     index,
	output logic                              done,
	output logic      [WIDTH-1:0]             front_value,
	output logic      [WIDTH-1:0]             rear_value,
	output logic      [$clog2(DEPTH+1)-1:0]   entry_count,
	output logic                              is_empty,
	output logic                              found,
	output logic      [WIDTH-1:0]             read_value,
	output logic                              overflow
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	state_t           state_q, state_d;
	op_t              op_q;
	logic [WIDTH-1:0] val_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    front_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_pos_q;
	logic [CW-1:0]    wr_pos_q;
	logic             vld_s1;
	logic             found_q;
	logic             ovf_q;
	logic [WIDTH-1:0] rd_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [WIDTH-1:0] wdata;
	logic [AW-1:0]    raddr_a;
	logic [AW-1:0]    raddr_b;
	logic [WIDTH-1:0] rdata_a;
	logic [WIDTH-1:0] rdata_b;

	logic             full;
	logic             issue;
	logic             skip;
	logic             idx_ok;
	logic [AW-1:0]    front_dec;
	logic [AW-1:0]    front_inc;

	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign issue     = (rd_pos_q < count_q);
	assign skip      = (rdata_a == val_q) && ((op_q == OP_DEL_ALL) || !found_q);
	assign idx_ok    = (CW'(idx_q) < count_q);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	bdq_mem #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_DEL_FIRST, OP_DEL_ALL: state_d = ST_SCAN;
					OP_READ:                  state_d = idx_ok ? ST_RDIDX : ST_FETCH;
					default:                  state_d = ST_FETCH;
				endcase
			end
			ST_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = ST_FETCH;
				end
			end
			ST_RDIDX: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we      = 1'b0;
		waddr   = front_q;
		wdata   = val_q;
		raddr_a = front_q;
		raddr_b = (count_q == '0) ? front_q : slot_add(front_q, count_q - CW'(1));
		case (state_q)
			ST_EXEC: begin
				raddr_a = slot_add(front_q, CW'(idx_q));
				if (op_q == OP_PUSH_FRONT) begin
					we    = !full;
					waddr = front_dec;
				end else if (op_q == OP_PUSH_BACK) begin
					we    = !full;
					waddr = slot_add(front_q, count_q);
				end
			end
			ST_SCAN: begin
				raddr_a = slot_add(front_q, rd_pos_q);
				we      = vld_s1 && !skip;
				waddr   = slot_add(front_q, wr_pos_q);
				wdata   = rdata_a;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_EXEC: begin
					vld_s1 <= 1'b0;
					case (op_q)
						OP_PUSH_FRONT: begin
							if (!full) begin
								front_q <= front_dec;
								count_q <= count_q + CW'(1);
							end
						end
						OP_PUSH_BACK: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_POP_FRONT: begin
							if (count_q != '0) begin
								front_q <= front_inc;
								count_q <= count_q - CW'(1);
							end
						end
						OP_POP_BACK: begin
							if (count_q != '0) begin
								count_q <= count_q - CW'(1);
							end
						end
						OP_CLEAR: begin
							front_q <= '0;
							count_q <= '0;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					if (!issue && !vld_s1) begin
						count_q <= wr_pos_q;
					end
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q    <= op_t'(mode);
					val_q   <= value;
					idx_q   <= index;
					found_q <= 1'b0;
					ovf_q   <= 1'b0;
					rd_q    <= '0;
				end
			end
			ST_EXEC: begin
				rd_pos_q <= '0;
				wr_pos_q <= '0;
				if ((op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK) && full) begin
					ovf_q <= 1'b1;
				end
				if (op_q == OP_READ && idx_ok) begin
					found_q <= 1'b1;
				end
			end
			ST_SCAN: begin
				if (issue) begin
					rd_pos_q <= rd_pos_q + CW'(1);
				end
				if (vld_s1) begin
					if (skip) begin
						if (op_q == OP_DEL_FIRST) begin
							found_q <= 1'b1;
						end
					end else begin
						wr_pos_q <= wr_pos_q + CW'(1);
					end
				end
			end
			ST_RDIDX: begin
				rd_q <= rdata_a;
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);
	assign front_value = (count_q != '0) ? rdata_a : '0;
	assign rear_value  = (count_q != '0) ? rdata_b : '0;
	assign entry_count = count_q;
	assign is_empty    = (count_q == '0);
	assign found       = found_q;
	assign read_value  = rd_q;
	assign overflow    = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(front_q) < DEPTH)
		else $error("front slot out of range");

	a_done_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FETCH))
		else $error("result without store fetch");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (count_q == CW'(DEPTH)))
		else $error("overflow flagged with room left");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (wr_pos_q <= rd_pos_q))
		else $error("compaction write ahead of read");

endmodule

`default_nettype wire

// ===== bench/tb_bounded_deque_with_match_delete.sv =====
// Self-checking testbench for the bounded deque with match deletion.
module tb_bounded_deque_with_match_delete;
	import bdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int WDOG_LIMIT = 2000;
	localparam int CALM_FIRST = 270;
	localparam int CALM_LAST = 420;

	typedef struct {
		op_t         op;
		logic [31:0] value;
		logic [3:0]  index;
		bit          settle;
	} command_t;

	typedef struct packed {
		logic [31:0] front_value;
		logic [31:0] rear_value;
		logic [4:0]  entry_count;
		logic        is_empty;
		logic        found;
		logic [31:0] read_value;
		logic        overflow;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  mode = OP_CLEAR;
	logic [31:0] value = '0;
	logic [3:0]  index = '0;
	logic        busy;
	logic        done;
	logic [31:0] front_value;
	logic [31:0] rear_value;
	logic [4:0]  entry_count;
	logic        is_empty;
	logic        found;
	logic [31:0] read_value;
	logic        overflow;

	command_t cmd_backlog[$];
	status_t  status_due[$];

	logic [31:0] model_slots [DEPTH];
	logic [3:0]  model_head = '0;
	logic [4:0]  model_count = '0;

	int       mismatches = 0;
	int       launched = 0;
	int       quiet_cycles = 0;
	bit       slot_free;
	bit       calm;
	command_t next_cmd;

	bounded_deque_with_match_delete u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.index      (index),
		.done       (done),
		.front_value(front_value),
		.rear_value (rear_value),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.found      (found),
		.read_value (read_value),
		.overflow   (overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] slot_at(input int pos);
		slot_at = model_head + pos[3:0];
	endfunction

	task automatic deque_apply(input op_t op, input logic [31:0] v, input logic [3:0] idx);
		status_t     s;
		int          k;
		int          w;
		int          hit_pos;
		bit          hit;
		logic [31:0] e;
		s = '0;
		hit = 0;
		hit_pos = 0;
		case (op)
			OP_PUSH_FRONT: begin
				if (model_count == DEPTH) begin
					s.overflow = 1'b1;
				end else begin
					model_head = model_head - 4'd1;
					model_slots[model_head] = v;
					model_count = model_count + 5'd1;
				end
			end
			OP_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					s.overflow = 1'b1;
				end else begin
					model_slots[slot_at(model_count)] = v;
					model_count = model_count + 5'd1;
				end
			end
			OP_POP_FRONT: begin
				if (model_count != 0) begin
					model_head = model_head + 4'd1;
					model_count = model_count - 5'd1;
				end
			end
			OP_POP_BACK: begin
				if (model_count != 0)
					model_count = model_count - 5'd1;
			end
			OP_DEL_FIRST: begin
				for (k = 0; k < model_count && !hit; k++) begin
					if (model_slots[slot_at(k)] == v) begin
						hit = 1;
						hit_pos = k;
					end
				end
				if (hit) begin
					for (w = hit_pos; w + 1 < model_count; w++)
						model_slots[slot_at(w)] = model_slots[slot_at(w + 1)];
					model_count = model_count - 5'd1;
					s.found = 1'b1;
				end
			end
			OP_DEL_ALL: begin
				w = 0;
				for (k = 0; k < model_count; k++) begin
					e = model_slots[slot_at(k)];
					if (e != v) begin
						model_slots[slot_at(w)] = e;
						w++;
					end
				end
				model_count = w[4:0];
			end
			OP_READ: begin
				if (idx < model_count) begin
					s.found = 1'b1;
					s.read_value = model_slots[slot_at(idx)];
				end
			end
			OP_CLEAR: begin
				model_count = '0;
				model_head = '0;
			end
		endcase
		if (model_count != 0) begin
			s.front_value = model_slots[model_head];
			s.rear_value = model_slots[slot_at(model_count - 1)];
		end
		s.entry_count = model_count;
		s.is_empty = (model_count == 0);
		status_due.push_back(s);
	endtask

	task automatic queue_cmd(input op_t op, input logic [31:0] v, input logic [3:0] idx,
			input bit settle = 0);
		command_t c;
		c.op = op;
		c.value = v;
		c.index = idx;
		c.settle = settle;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: pick_value = $urandom_range(0, 5);
			6: pick_value = '0;
			7: pick_value = '1;
			default: pick_value = $urandom();
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, actual %0h", name, exp, act);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= OP_CLEAR;
			value <= '0;
			index <= '0;
		end else begin
			slot_free = !start || !busy;
			if (start && !busy)
				deque_apply(op_t'(mode), value, index);
			calm = launched >= CALM_FIRST && launched < CALM_LAST;
			if (slot_free) begin
				if (cmd_backlog.size() != 0
						&& !(cmd_backlog[0].settle && status_due.size() != 0)
						&& (calm || $urandom_range(0, 99) >= 10)) begin
					next_cmd = cmd_backlog.pop_front();
					start <= 1'b1;
					mode <= next_cmd.op;
					value <= next_cmd.value;
					index <= next_cmd.index;
					launched++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (status_due.size() == 0) begin
				$error("result word with no pending command");
				mismatches++;
			end else begin
				check_field("front_value", status_due[0].front_value, front_value);
				check_field("rear_value", status_due[0].rear_value, rear_value);
				check_field("entry_count", status_due[0].entry_count, entry_count);
				check_field("is_empty", status_due[0].is_empty, is_empty);
				check_field("found", status_due[0].found, found);
				check_field("read_value", status_due[0].read_value, read_value);
				check_field("overflow", status_due[0].overflow, overflow);
				void'(status_due.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int     b;
		int     n;
		int     r;
		int     push_pct;
		op_t    op;
		for (n = 0; n < DEPTH; n++)
			model_slots[n] = '0;

		queue_cmd(OP_CLEAR, '0, 4'd0);
		queue_cmd(OP_POP_FRONT, '0, 4'd0);
		queue_cmd(OP_POP_BACK, '0, 4'd0);
		queue_cmd(OP_DEL_FIRST, '0, 4'd0);
		queue_cmd(OP_DEL_ALL, '0, 4'd0);
		queue_cmd(OP_READ, '0, 4'd0);
		queue_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd15);
		queue_cmd(OP_PUSH_FRONT, 32'h0, 4'd0);
		queue_cmd(OP_PUSH_BACK, 32'h3, 4'd0);
		queue_cmd(OP_PUSH_FRONT, 32'h3, 4'd0);
		queue_cmd(OP_READ, '0, 4'd3);
		queue_cmd(OP_READ, '0, 4'd15);
		queue_cmd(OP_DEL_FIRST, 32'h3, 4'd0);
		queue_cmd(OP_DEL_ALL, 32'h5, 4'd0);
		queue_cmd(OP_DEL_FIRST, 32'h5, 4'd0);
		queue_cmd(OP_DEL_ALL, 32'h3, 4'd0);
		queue_cmd(OP_POP_FRONT, '0, 4'd0);
		queue_cmd(OP_POP_BACK, '0, 4'd0);
		queue_cmd(OP_PUSH_BACK, 32'h7, 4'd0);
		queue_cmd(OP_DEL_FIRST, 32'h7, 4'd0);
		queue_cmd(OP_PUSH_FRONT, 32'hAAAA_5555, 4'd0);
		queue_cmd(OP_DEL_ALL, 32'hAAAA_5555, 4'd0);

		// alternate filling, balanced and draining bursts
		for (b = 0; b < 12; b++) begin
			push_pct = (b % 3 == 0) ? 85 : (b % 3 == 1) ? 45 : 15;
			for (n = 0; n < 50; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					op = OP_CLEAR;
				else if (r < 3 + push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else begin
					case ($urandom_range(0, 4))
						0: op = OP_POP_FRONT;
						1: op = OP_POP_BACK;
						2: op = OP_DEL_FIRST;
						3: op = OP_DEL_ALL;
						default: op = OP_READ;
					endcase
				end
				queue_cmd(op, pick_value(), 4'($urandom_range(0, 15)), n == 0);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || start || status_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== bounded_deque_with_match_delete.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_mem.sv
hw/rtl/bounded_deque_with_match_delete.sv
bench/tb_bounded_deque_with_match_delete.sv
